// File: sv/otb_pkg.sv
`timescale 1ns / 1ps
// otb_pkg: shared types, codes and arithmetic helpers of the one-shot timer bank.
// No dependencies; otb_clock, otb_scan and the top level import it, otb_ram does not.
package otb_pkg;

  localparam int TIMER_SLOTS_DEF = 8;

  localparam logic [62:0] MAX63     = {63{1'b1}};
  localparam logic [9:0]  MS_TO_US  = 10'd1000;
  localparam int          PROD_W    = 42;

  // request codes
  localparam logic [2:0] REQ_ALLOC = 3'd0;
  localparam logic [2:0] REQ_ARM   = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_FREE  = 3'd3;
  localparam logic [2:0] REQ_ADV   = 3'd4;
  localparam logic [2:0] REQ_HOST  = 3'd5;

  // completion status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD     = 2'd1;
  localparam logic [1:0] STAT_NO_FREE = 2'd2;

  // result kinds
  localparam logic EV_DONE = 1'b0;
  localparam logic EV_FIRE = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  slot;
    logic [63:0] delay_us;
    logic [31:0] advance_us;
    logic [31:0] host_ms;
  } in_req_t;

  typedef struct packed {
    logic        event_kind;
    logic [2:0]  slot_out;
    logic [1:0]  status;
    logic [62:0] now_us;
    logic        last;
  } out_rsp_t;

  // clock unit controls
  typedef struct packed {
    logic adv;       // add advance_us to the clock
    logic host_mul;  // form host delta times 1000
    logic host_upd;  // fold product into floor, raise clock
  } clk_ctl_t;

  // fire scan status
  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

  function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[63] ? MAX63 : sum[62:0];
  endfunction

endpackage

// File: sv/otb_ram.sv
`timescale 1ns / 1ps
// otb_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module otb_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/otb_clock.sv
`timescale 1ns / 1ps
// otb_clock: virtual microsecond clock, host floor and host millisecond tracking.
// Depends on otb_pkg.
module otb_clock
  import otb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  clk_ctl_t    ctl,
  input  logic [31:0] advance_us,
  input  logic [31:0] host_ms,
  output logic [62:0] clock_us
);

  logic [62:0]       clock_r, clock_nxt;
  logic [62:0]       floor_r, floor_nxt;
  logic [31:0]       prev_host_r;
  logic              host_seen_r;
  logic [PROD_W-1:0] prod_r;
  logic [31:0]       host_delta;

  assign host_delta = host_seen_r ? (host_ms - prev_host_r) : host_ms;

  always_comb begin
    clock_nxt = clock_r;
    floor_nxt = floor_r;
    if (ctl.adv) begin
      clock_nxt = sat_add63(clock_r, {31'b0, advance_us});
    end else if (ctl.host_upd) begin
      floor_nxt = host_seen_r ? sat_add63(floor_r, 63'(prod_r)) : 63'(prod_r);
      if (floor_nxt > clock_r) begin
        clock_nxt = floor_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r     <= '0;
      floor_r     <= '0;
      prev_host_r <= '0;
      host_seen_r <= 1'b0;
    end else begin
      clock_r <= clock_nxt;
      floor_r <= floor_nxt;
      if (ctl.host_upd) begin
        prev_host_r <= host_ms;
        host_seen_r <= 1'b1;
      end
    end
  end

  // product register: needs no reset
  always_ff @(posedge clk) begin
    if (ctl.host_mul) begin
      prod_r <= PROD_W'(host_delta) * PROD_W'(MS_TO_US);
    end
  end

  assign clock_us = clock_r;

endmodule

// File: sv/otb_scan.sv
`timescale 1ns / 1ps
// otb_scan: one pass over the deadline RAM that picks the earliest due armed timer.
// Depends on otb_pkg; drives the read port of the deadline RAM.
module otb_scan
  import otb_pkg::*;
#(
  parameter int N      = TIMER_SLOTS_DEF,
  parameter int SLOT_W = (N > 1) ? $clog2(N) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [62:0]       clock_us,
  input  logic [N-1:0]      armed_vec,
  input  logic [62:0]       rd_data,
  output logic [SLOT_W-1:0] rd_addr,
  output scan_stat_t        stat,
  output logic [SLOT_W-1:0] best
);

  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(N - 1);

  logic              active_r;
  logic [SLOT_W-1:0] idx_r;
  logic              chk_v_r;
  logic [SLOT_W-1:0] chk_idx_r;
  logic              found_r;
  logic [SLOT_W-1:0] best_r;
  logic [62:0]       best_dl_r;
  logic              cand;

  // data for chk_idx_r arrives in the cycle after its address
  assign cand = chk_v_r && armed_vec[chk_idx_r] && (rd_data <= clock_us) &&
                (!found_r || (rd_data < best_dl_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      chk_v_r  <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      chk_v_r <= active_r;
      if (start) begin
        active_r <= 1'b1;
        idx_r    <= '0;
        found_r  <= 1'b0;
      end else begin
        if (active_r) begin
          if (idx_r == LAST) begin
            active_r <= 1'b0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        if (cand) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= idx_r;
    if (cand) begin
      best_r    <= chk_idx_r;
      best_dl_r <= rd_data;
    end
  end

  assign rd_addr    = idx_r;
  assign stat.done  = chk_v_r && (chk_idx_r == LAST);
  assign stat.found = found_r || cand;
  assign best       = cand ? chk_idx_r : best_r;

  a_scan_pick_armed: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done && stat.found |-> armed_vec[best])
    else $error("scan picked a slot that is not armed");

  a_scan_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> active_r && !chk_v_r)
    else $error("scan restarted while a pass was running");

  a_scan_pick_due: assert property (@(posedge clk) disable iff (!rst_n)
    cand |-> rd_data <= clock_us)
    else $error("scan picked a deadline after the clock");

endmodule

// File: sv/oneshot_timer_bank_unit.sv
`timescale 1ns / 1ps
// oneshot_timer_bank_unit: top level of the one-shot timer bank.
// Depends on otb_pkg, otb_ram, otb_clock and otb_scan.
//
//  Channel | Ports                          | Direction | Moves
//  --------+--------------------------------+-----------+-------------------------------
//  in      | in_valid, in_ready, in_data    | into bank | one command request
//  out     | out_valid, out_ready, out_data | out       | completion, then any fires
//
// Flow: one request at a time. Allocate, arm, stop, free and unknown requests go from
// the execute step straight to the emit step and the output register; host milliseconds
// passes the multiplier, then the floor add and a settle step first. An advance runs one
// pass over the deadline RAM per result, each followed by an emit step, so with k fires
// there are k+1 passes before the last result reaches the output register; the single
// RAM read port keeps the passes serial.
// Reset: synchronous, active low; clears the clock, floor, host tracking and the slot
// in-use and armed bits. Deadlines are not cleared; an entry counts only once armed.
// Stalls: a held out_ready freezes the flow in the emit step; the output register
// holds its result until taken.
module oneshot_timer_bank_unit
  import otb_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_HMUL = 3'd2;
  localparam logic [2:0] S_HUPD = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]             state_r, state_nxt;
  in_req_t                req_r;
  logic [TIMER_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [TIMER_SLOTS-1:0] armed_r, armed_nxt;
  logic                   more_r, more_nxt;       // another scan follows this emit
  logic [SLOT_W-1:0]      best_r, best_nxt;
  logic                   pend_kind_r, pend_kind_nxt;
  logic [2:0]             pend_slot_r, pend_slot_nxt;
  logic [1:0]             pend_stat_r, pend_stat_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_rsp_t               out_data_r;

  logic              in_fire;
  logic              push;
  logic              scan_start;
  clk_ctl_t          clk_ctl;
  logic [62:0]       clock_us;
  logic              slot_ok;
  logic [SLOT_W-1:0] slot_idx;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [62:0]       tmo63;
  logic              ram_we;
  logic [62:0]       ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [62:0]       ram_rdata;
  scan_stat_t        scan_stat;
  logic [SLOT_W-1:0] scan_best;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign push     = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // addressed slot: must exist and be allocated
  assign slot_idx = SLOT_W'(req_r.slot);
  assign slot_ok  = (32'(req_r.slot) < TIMER_SLOTS) && in_use_r[slot_idx];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // deadline = now + timeout, both capped at the 63-bit maximum
  assign tmo63     = req_r.delay_us[63] ? MAX63 : req_r.delay_us[62:0];
  assign ram_wdata = sat_add63(clock_us, tmo63);
  assign ram_we    = (state_r == S_EXEC) && (req_r.req_type == REQ_ARM) && slot_ok;

  always_comb begin
    state_nxt     = state_r;
    in_use_nxt    = in_use_r;
    armed_nxt     = armed_r;
    more_nxt      = more_r;
    best_nxt      = best_r;
    pend_kind_nxt = pend_kind_r;
    pend_slot_nxt = pend_slot_r;
    pend_stat_nxt = pend_stat_r;
    clk_ctl       = '0;
    scan_start    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // every request opens with a completion
        pend_kind_nxt = EV_DONE;
        pend_slot_nxt = '0;
        pend_stat_nxt = STAT_OK;
        more_nxt      = 1'b0;
        state_nxt     = S_EMIT;
        unique case (req_r.req_type)
          REQ_ALLOC: begin
            if (free_found) begin
              in_use_nxt[free_idx] = 1'b1;
              armed_nxt[free_idx]  = 1'b0;
              pend_slot_nxt        = 3'(free_idx);
            end else begin
              pend_stat_nxt = STAT_NO_FREE;
            end
          end
          REQ_ARM: begin
            if (slot_ok) begin
              armed_nxt[slot_idx] = 1'b1;
            end else begin
              pend_stat_nxt = STAT_BAD;
            end
          end
          REQ_STOP: begin
            if (slot_ok) begin
              armed_nxt[slot_idx] = 1'b0;
            end else begin
              pend_stat_nxt = STAT_BAD;
            end
          end
          REQ_FREE: begin
            if (slot_ok) begin
              in_use_nxt[slot_idx] = 1'b0;
              armed_nxt[slot_idx]  = 1'b0;
            end else begin
              pend_stat_nxt = STAT_BAD;
            end
          end
          REQ_ADV: begin
            // advance the clock now; the scan compares only after it lands
            clk_ctl.adv = 1'b1;
            scan_start  = 1'b1;
            state_nxt   = S_SCAN;
          end
          REQ_HOST: begin
            clk_ctl.host_mul = 1'b1;
            state_nxt        = S_HMUL;
          end
          default: begin
            pend_stat_nxt = STAT_BAD;
          end
        endcase
      end
      S_HMUL: begin
        clk_ctl.host_upd = 1'b1;
        state_nxt        = S_HUPD;
      end
      S_HUPD: begin
        // clock settles here; completion is emitted next
        state_nxt = S_EMIT;
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          more_nxt  = scan_stat.found;
          best_nxt  = scan_best;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (push) begin
          if (more_r) begin
            // turn the picked timer into the next pending fire and look again
            armed_nxt[best_r] = 1'b0;
            pend_kind_nxt     = EV_FIRE;
            pend_slot_nxt     = 3'(best_r);
            pend_stat_nxt     = STAT_OK;
            scan_start        = 1'b1;
            state_nxt         = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = push || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      armed_r     <= '0;
      more_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      armed_r     <= armed_nxt;
      more_r      <= more_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_stat_r <= pend_stat_nxt;
    if (in_fire) begin
      req_r <= in_data;
    end
    if (push) begin
      out_data_r.event_kind <= pend_kind_r;
      out_data_r.slot_out   <= pend_slot_r;
      out_data_r.status     <= pend_stat_r;
      out_data_r.now_us     <= clock_us;
      out_data_r.last       <= !more_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  otb_clock u_clock (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (clk_ctl),
    .advance_us (req_r.advance_us),
    .host_ms    (req_r.host_ms),
    .clock_us   (clock_us)
  );

  otb_ram #(
    .WIDTH (63),
    .DEPTH (TIMER_SLOTS),
    .AW    (SLOT_W)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  otb_scan #(
    .N      (TIMER_SLOTS),
    .SLOT_W (SLOT_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .clock_us  (clock_us),
    .armed_vec (in_use_r & armed_r),
    .rd_data   (ram_rdata),
    .rd_addr   (ram_raddr),
    .stat      (scan_stat),
    .best      (scan_best)
  );

  a_armed_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (armed_r & ~in_use_r) == '0)
    else $error("armed slot is not allocated");

  a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> clock_us >= $past(clock_us))
    else $error("virtual clock went backward");

  a_no_free_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && (pend_kind_r == EV_DONE) && (pend_stat_r == STAT_NO_FREE) |-> (&in_use_r))
    else $error("no-free status with a free slot");

  a_fire_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pend_kind_r == EV_DONE) || (state_r == S_EXEC))
    else $error("request started while a fire was pending");

endmodule
